/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/lpr_pkg.sv */
package lpr_pkg;

  // Framebuffer geometry
  localparam int unsigned ROW_BYTES       = 128;
  localparam int unsigned DEF_COORD_BITS  = 8;
  localparam int unsigned IDX_BITS        = 10;
  localparam int unsigned MASK_BITS       = 8;
  localparam int unsigned PAGE_SHIFT      = 3;

  // Config register port
  localparam int unsigned WIDTH_BITS      = 8;
  localparam int unsigned HEIGHT_BITS     = 7;
  localparam int unsigned PADDR_BITS      = 3;
  localparam int unsigned PDATA_BITS      = 32;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 8'd128;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 7'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic last;
  } step_ctrl_t;

endpackage

/* rtl/core/line_pixel_rasterizer.sv */
// A step word accepted at a clock edge while a line is active shows its pixel
// on the outputs right after that edge.
// Throughput: one word per cycle while the output drains; a pixel word held by
// out_ready_i low keeps in_ready_o low, load words included.
// Load words produce no output. Reset: no line active, output empty,
// screen_width = 128, screen_height = 64.
module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  visible_o,
  output logic [IDX_BITS-1:0]   byte_index_o,
  output logic [MASK_BITS-1:0]  bit_mask_o,
  output logic                  last_o
);

  localparam int unsigned DATA_W = 2 * COORD_BITS + 1 + IDX_BITS + MASK_BITS + 1;

  cfg_t                  cfg;
  step_ctrl_t            ctrl;
  logic                  in_fire, load, step, slot_free;
  logic [COORD_BITS-1:0] px, py;
  logic                  vis;
  logic [IDX_BITS-1:0]   idx;
  logic [MASK_BITS-1:0]  mask;
  logic [DATA_W-1:0]     res_word, out_word;

  lpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input handshake
  assign in_ready_o = slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = in_fire && (op_i == OP_LOAD);
  assign step       = in_fire && (op_i == OP_STEP);

  lpr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .step_i    (step),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .px_o      (px),
    .py_o      (py),
    .ctrl_o    (ctrl)
  );

  lpr_pixel_map #(.COORD_BITS(COORD_BITS)) u_map (
    .px_i         (px),
    .py_i         (py),
    .cfg_i        (cfg),
    .visible_o    (vis),
    .byte_index_o (idx),
    .bit_mask_o   (mask)
  );

  assign res_word = {px, py, vis, idx, mask, ctrl.last};

  lpr_out_buf #(.DATA_W(DATA_W)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctrl.emit),
    .data_i  (res_word),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (slot_free),
    .data_o  (out_word)
  );

  assign {pixel_x_o, pixel_y_o, visible_o, byte_index_o, bit_mask_o, last_o} = out_word;

endmodule

/* rtl/core/lpr_regs.sv */
module lpr_regs
  import lpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  cfg_d.width  = pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT: cfg_d.height = pwdata[HEIGHT_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = PDATA_BITS'(cfg_q.width);
      REG_HEIGHT: prdata = PDATA_BITS'(cfg_q.height);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/lpr_walker.sv */
module lpr_walker
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  step_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic [COORD_BITS-1:0] px_o,
  output logic [COORD_BITS-1:0] py_o,
  output step_ctrl_t            ctrl_o
);

  // Error term spans -2*major .. 2*minor, plus sign
  localparam int unsigned ERR_BITS = COORD_BITS + 3;

  logic                        active_q, active_d;
  logic                        steep_q, steep_d;
  logic                        dir_neg_q, dir_neg_d;
  logic [COORD_BITS-1:0]       maj_pos_q, maj_pos_d;
  logic [COORD_BITS-1:0]       min_pos_q, min_pos_d;
  logic [COORD_BITS-1:0]       maj_end_q, maj_end_d;
  logic [COORD_BITS-1:0]       maj_dlt_q, maj_dlt_d;
  logic [COORD_BITS-1:0]       min_dlt_q, min_dlt_d;
  logic signed [ERR_BITS-1:0]  err_q, err_d;

  // Load-side setup
  logic [COORD_BITS-1:0] adx, ady;
  logic                  ld_steep, ld_swap;
  logic [COORD_BITS-1:0] ma_r, mb_r, mia_r, mib_r;
  logic [COORD_BITS-1:0] ma, mb, mia, mib;
  logic [COORD_BITS-1:0] ld_min_dlt;
  logic signed [ERR_BITS-1:0] ld_err;

  // Step-side update
  logic                       is_last, err_pos;
  logic signed [ERR_BITS-1:0] two_maj, two_min, err_dec;

  always_comb begin
    adx      = (x_start_i > x_end_i) ? x_start_i - x_end_i : x_end_i - x_start_i;
    ady      = (y_start_i > y_end_i) ? y_start_i - y_end_i : y_end_i - y_start_i;
    ld_steep = adx < ady;
    ma_r     = ld_steep ? y_start_i : x_start_i;
    mia_r    = ld_steep ? x_start_i : y_start_i;
    mb_r     = ld_steep ? y_end_i   : x_end_i;
    mib_r    = ld_steep ? x_end_i   : y_end_i;
    // walk the major axis upward
    ld_swap  = mb_r < ma_r;
    ma       = ld_swap ? mb_r  : ma_r;
    mb       = ld_swap ? ma_r  : mb_r;
    mia      = ld_swap ? mib_r : mia_r;
    mib      = ld_swap ? mia_r : mib_r;
    ld_min_dlt = (mib > mia) ? mib - mia : mia - mib;
    ld_err   = $signed({2'b00, ld_min_dlt, 1'b0}) - $signed({3'b000, mb - ma});
  end

  always_comb begin
    is_last = maj_pos_q == maj_end_q;
    err_pos = !err_q[ERR_BITS-1] && (err_q != '0);
    two_maj = $signed({2'b00, maj_dlt_q, 1'b0});
    two_min = $signed({2'b00, min_dlt_q, 1'b0});
    err_dec = err_pos ? err_q - two_maj : err_q;
  end

  // Next-state selection: load wins, else one Bresenham step
  always_comb begin
    active_d  = active_q;
    steep_d   = steep_q;
    dir_neg_d = dir_neg_q;
    maj_pos_d = maj_pos_q;
    min_pos_d = min_pos_q;
    maj_end_d = maj_end_q;
    maj_dlt_d = maj_dlt_q;
    min_dlt_d = min_dlt_q;
    err_d     = err_q;
    if (load_i) begin
      active_d  = 1'b1;
      steep_d   = ld_steep;
      dir_neg_d = mib < mia;
      maj_pos_d = ma;
      min_pos_d = mia;
      maj_end_d = mb;
      maj_dlt_d = mb - ma;
      min_dlt_d = ld_min_dlt;
      err_d     = ld_err;
    end else if (step_i && active_q) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        if (err_pos) begin
          min_pos_d = dir_neg_q ? min_pos_q - 1'b1 : min_pos_q + 1'b1;
        end
        err_d     = err_dec + two_min;
        maj_pos_d = maj_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      steep_q   <= 1'b0;
      dir_neg_q <= 1'b0;
      maj_pos_q <= '0;
      min_pos_q <= '0;
      maj_end_q <= '0;
      maj_dlt_q <= '0;
      min_dlt_q <= '0;
      err_q     <= '0;
    end else begin
      active_q  <= active_d;
      steep_q   <= steep_d;
      dir_neg_q <= dir_neg_d;
      maj_pos_q <= maj_pos_d;
      min_pos_q <= min_pos_d;
      maj_end_q <= maj_end_d;
      maj_dlt_q <= maj_dlt_d;
      min_dlt_q <= min_dlt_d;
      err_q     <= err_d;
    end
  end

  // Current pixel, before the step advances
  assign px_o        = steep_q ? min_pos_q : maj_pos_q;
  assign py_o        = steep_q ? maj_pos_q : min_pos_q;
  assign ctrl_o.emit = step_i && active_q && !load_i;
  assign ctrl_o.last = is_last;

endmodule

/* rtl/core/lpr_pixel_map.sv */
module lpr_pixel_map
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  cfg_t                  cfg_i,
  output logic                  visible_o,
  output logic [IDX_BITS-1:0]   byte_index_o,
  output logic [MASK_BITS-1:0]  bit_mask_o
);

  localparam int unsigned CMP_W = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;

  logic [IDX_BITS-1:0] page, row_base;

  // Clip against the programmed screen size
  assign visible_o = (CMP_W'(px_i) < CMP_W'(cfg_i.width)) &&
                     (CMP_W'(py_i) < CMP_W'(cfg_i.height));

  // Page-organized address: eight rows per byte row
  assign page         = IDX_BITS'(py_i >> PAGE_SHIFT);
  assign row_base     = IDX_BITS'(page * IDX_BITS'(ROW_BYTES));
  assign byte_index_o = visible_o ? row_base + IDX_BITS'(px_i) : '0;

  assign bit_mask_o = MASK_BITS'(1) << py_i[PAGE_SHIFT-1:0];

endmodule

/* rtl/core/lpr_out_buf.sv */
module lpr_out_buf
  import lpr_pkg::*;
#(
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              ready_i,
  output logic              valid_o,
  output logic              free_o,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q;

  // Slot is free when empty or draining this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lpr_checker.sv */
`include "assert_macros.svh"

module lpr_checker
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  op_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] pixel_x_o,
  input logic [COORD_BITS-1:0] pixel_y_o,
  input logic                  visible_o,
  input logic [IDX_BITS-1:0]   byte_index_o,
  input logic [MASK_BITS-1:0]  bit_mask_o,
  input logic                  last_o
);

  // A stalled output word holds
  `LPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_o), "output word changed while stalled")

  // Clipped pixels carry a zero address
  `LPR_ASSERT(a_clip_idx, clk_i, rst_ni, (out_valid_o && !visible_o) |-> (byte_index_o == '0), "nonzero byte index on clipped pixel")

  // Mask selects the row inside the page
  `LPR_ASSERT(a_mask_row, clk_i, rst_ni, out_valid_o |-> (bit_mask_o == (MASK_BITS'(1) << pixel_y_o[PAGE_SHIFT-1:0])), "bit mask does not match pixel row")

  // A load word never produces output
  `LPR_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i == OP_LOAD), !out_valid_o, "output after load word")

endmodule

bind line_pixel_rasterizer lpr_checker #(.COORD_BITS(COORD_BITS)) u_lpr_checker (.*);
